[rtl/circular_deque_macros.svh]
// assertion macros shared by the circular deque modules
// expects clk and rst_n in the scope of each use
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// same-cycle implication
`define CDQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular_deque check failed");

// next-cycle implication
`define CDQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular_deque check failed");

`endif

[rtl/cdq_pkg.sv]
// package for the circular deque: sizes, request and status codes,
// and the update struct passed from the control to the top level
package cdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_REPORT     = 3'd4
    } cdq_req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } cdq_status_t;

    typedef struct packed {
        logic              valid;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] front_addr;
        logic [ADDR_W-1:0] back_addr;
        cdq_status_t       status;
        logic [CNT_W-1:0]  count;
        logic              full;
    } cdq_upd_t;

    // capacity write: zero reads as one, anything above the depth as the depth
    function automatic logic [CNT_W-1:0] limit_cap(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (v > CNT_W'(DEPTH))
        begin
            r = CNT_W'(DEPTH);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/cdq_ctrl.sv]
// head, count and capacity registers of the circular deque and the
// per-request index step; depends on cdq_pkg and circular_deque_macros.svh
`include "circular_deque_macros.svh"

module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [REQ_W-1:0] req_type,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_cap,
    output cdq_upd_t         upd
);

    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  cap_reg;

    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic [CNT_W-1:0]  tail_sum;
    logic [ADDR_W-1:0] tail_pos;
    logic [CNT_W-1:0]  back_sum;
    logic [ADDR_W-1:0] back_pos;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    cdq_status_t       status;
    logic              refused_push;

    always_comb
    begin
        full  = count_reg >= cap_reg;
        empty = count_reg == '0;

        // neighbors of the head inside the active ring
        head_dec = (head_reg == '0) ? ADDR_W'(cap_reg - CNT_W'(1))
                                    : ADDR_W'(head_reg - ADDR_W'(1));
        head_inc = ((CNT_W'(head_reg) + CNT_W'(1)) == cap_reg) ? '0
                                    : ADDR_W'(head_reg + ADDR_W'(1));
        // slot just past the back
        tail_sum = CNT_W'(head_reg) + count_reg;
        tail_pos = (tail_sum >= cap_reg) ? ADDR_W'(tail_sum - cap_reg)
                                         : ADDR_W'(tail_sum);

        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_pos;
        status     = ST_DONE;

        case (req_type)
            REQ_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    head_next  = head_dec;
                    wr_en      = 1'b1;
                    wr_addr    = head_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = tail_pos;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase

        // back after the request, don't care when empty
        back_sum = CNT_W'(head_next) + count_next - CNT_W'(1);
        back_pos = (back_sum >= cap_reg) ? ADDR_W'(back_sum - cap_reg)
                                         : ADDR_W'(back_sum);

        upd.valid      = accept;
        upd.wr_en      = accept & wr_en;
        upd.wr_addr    = wr_addr;
        upd.front_addr = head_next;
        upd.back_addr  = back_pos;
        upd.status     = status;
        upd.count      = count_next;
        upd.full       = count_next >= cap_reg;
    end

    // accepted push turned away because the ring is full
    assign refused_push = accept && !cfg_we && (status == ST_FULL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= limit_cap(CNT_W'(16));
        end
        else if (cfg_we)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= limit_cap(cfg_cap);
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    `CDQ_ASSERT_IMPL(a_count_in_cap, 1'b1, count_reg <= cap_reg)
    `CDQ_ASSERT_IMPL(a_head_in_ring, 1'b1, CNT_W'(head_reg) < cap_reg)
    `CDQ_ASSERT_NEXT(a_refused_push_holds, refused_push, $stable(count_reg) && $stable(head_reg))

endmodule

[rtl/cdq_store.sv]
// ring store of the circular deque: one write port, two registered reads
// with write-through bypass; depends on cdq_pkg
module cdq_store
    import cdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [ADDR_W-1:0]     front_addr,
    input  logic [ADDR_W-1:0]     back_addr,
    output logic [DATA_WIDTH-1:0] front_data,
    output logic [DATA_WIDTH-1:0] back_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] front_raw_reg;
    logic [DATA_WIDTH-1:0] back_raw_reg;
    logic [DATA_WIDTH-1:0] wr_data_reg;
    logic                  front_byp_reg;
    logic                  back_byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // reads see the old contents; a same-cycle write wins through the bypass
    always_ff @(posedge clk)
    begin
        front_raw_reg <= mem[front_addr];
        back_raw_reg  <= mem[back_addr];
        wr_data_reg   <= wr_data;
        front_byp_reg <= wr_en && (wr_addr == front_addr);
        back_byp_reg  <= wr_en && (wr_addr == back_addr);
    end

    assign front_data = front_byp_reg ? wr_data_reg : front_raw_reg;
    assign back_data  = back_byp_reg  ? wr_data_reg : back_raw_reg;

endmodule

[rtl/circular_deque.sv]
// top level of the circular deque: request port, capacity write port,
// result register; depends on cdq_pkg, cdq_ctrl, cdq_store, macros header
//
//  channel   handshake             payload
//  request   start, busy           req_type, value
//  capacity  cfg_valid, cfg_ready  active_capacity
//  result    done (strobe)         status, front_value, back_value, count,
//                                  is_empty, is_full
//
// one request per cycle; busy stays low, so start alone accepts
// a result strobes after its request: the store read port and request stage
// register first, then the result register loads
// reset empties the deque and sets the capacity to the full depth;
// the store itself is not cleared
// a capacity write empties the deque; results cannot be held off
`include "circular_deque_macros.svh"

module circular_deque
    import cdq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [REQ_W-1:0]             req_type,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CNT_W-1:0]             active_capacity,
    output logic                         done,
    output logic [STATUS_W-1:0]          status,
    output logic signed [DATA_WIDTH-1:0] front_value,
    output logic signed [DATA_WIDTH-1:0] back_value,
    output logic [CNT_W-1:0]             count,
    output logic                         is_empty,
    output logic                         is_full
);

    cdq_upd_t upd;
    logic     accept;
    logic     cfg_we;

    logic [DATA_WIDTH-1:0] front_data;
    logic [DATA_WIDTH-1:0] back_data;

    // request stage: state updated, store read in flight
    logic              a_valid_reg;
    cdq_status_t       a_status_reg;
    logic [CNT_W-1:0]  a_count_reg;
    logic              a_full_reg;

    // result register
    logic                  done_reg;
    cdq_status_t           status_reg;
    logic [DATA_WIDTH-1:0] front_reg;
    logic [DATA_WIDTH-1:0] back_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  empty_reg;
    logic                  full_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .cfg_we   (cfg_we),
        .cfg_cap  (active_capacity),
        .upd      (upd)
    );

    cdq_store u_store (
        .clk        (clk),
        .wr_en      (upd.wr_en),
        .wr_addr    (upd.wr_addr),
        .wr_data    (value),
        .front_addr (upd.front_addr),
        .back_addr  (upd.back_addr),
        .front_data (front_data),
        .back_data  (back_data)
    );

    // request stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= upd.valid;
        end
    end

    // request stage payload
    always_ff @(posedge clk)
    begin
        if (upd.valid)
        begin
            a_status_reg <= upd.status;
            a_count_reg  <= upd.count;
            a_full_reg   <= upd.full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= a_valid_reg;
        end
    end

    // empty deque reports zero at both ends
    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            status_reg <= a_status_reg;
            count_reg  <= a_count_reg;
            empty_reg  <= a_count_reg == '0;
            full_reg   <= a_full_reg;
            front_reg  <= (a_count_reg == '0) ? '0 : front_data;
            back_reg   <= (a_count_reg == '0) ? '0 : back_data;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;
    assign count       = count_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;

    `CDQ_ASSERT_NEXT(a_two_cycle_result, a_valid_reg, done)
    `CDQ_ASSERT_IMPL(a_empty_flag, done, is_empty == (count == '0))
    `CDQ_ASSERT_IMPL(a_empty_ends_zero, done && is_empty, front_value == '0 && back_value == '0)

endmodule
